### hdl/pdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_pkg: shared types and constants for the polar iteration block
// Register indexes, status codes, the arithmetic unit request and the
// cofactor operand table.
// ----------------------------------------------------------------------------
package pdi_pkg;

	localparam logic [1:0] CFG_TOLERANCE   = 2'd0;
	localparam logic [1:0] CFG_ITER_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_LIMIT_FATAL = 2'd2;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_LIMIT     = 2'd1;
	localparam logic [1:0] ST_FATAL     = 2'd2;
	localparam logic [1:0] ST_SINGULAR  = 2'd3;

	typedef struct packed {
		logic start;
		logic op_div;
	} arith_req_t;

	typedef struct packed {
		logic [3:0] a1;
		logic [3:0] b1;
		logic [3:0] a2;
		logic [3:0] b2;
	} cof_idx_t;

	// Cofactor k is x[a1]*x[b1] - x[a2]*x[b2], row-major indexes.
	function automatic cof_idx_t cof_idx(input logic [3:0] k);
		cof_idx_t r;
		case (k)
			4'd0: r = '{4'd4, 4'd8, 4'd5, 4'd7};
			4'd1: r = '{4'd5, 4'd6, 4'd3, 4'd8};
			4'd2: r = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'd3: r = '{4'd7, 4'd2, 4'd8, 4'd1};
			4'd4: r = '{4'd8, 4'd0, 4'd6, 4'd2};
			4'd5: r = '{4'd6, 4'd1, 4'd7, 4'd0};
			4'd6: r = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'd7: r = '{4'd2, 4'd3, 4'd0, 4'd5};
			4'd8: r = '{4'd0, 4'd4, 4'd1, 4'd3};
			default: r = '{4'd0, 4'd0, 4'd0, 4'd0};
		endcase
		return r;
	endfunction

endpackage

### hdl/pdi_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_arith: shared bit-serial multiply and divide unit
// Rounded saturating fixed-point product, or truncating saturating
// fixed-point quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module pdi_arith #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pdi_pkg::arith_req_t            req,
	input  logic signed [DATA_WIDTH-1:0]   a,
	input  logic signed [DATA_WIDTH-1:0]   b,
	output logic                           done,
	output logic signed [DATA_WIDTH-1:0]   result
);
	import pdi_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int LW = (2 * W > W + FRAC_BITS) ? 2 * W : W + FRAC_BITS;
	localparam int CW = $clog2(W + FRAC_BITS + 1);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_RUN  = 2'd1;
	localparam logic [1:0] U_FIN  = 2'd2;

	localparam logic [LW:0] RND = (LW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [LW:0] LIM = (LW + 1)'(1) << (W - 1);
	localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};

	logic [1:0]    ustate_q;
	logic          op_div_q;
	logic          neg_q;
	logic [LW-1:0] acc_q;
	logic [LW-1:0] sh_q;
	logic [W-1:0]  mplr_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  result_q;
	logic          done_q;

	logic [W-1:0]  ma;
	logic [W-1:0]  mb;
	logic [W:0]    trial;
	logic          fits;
	logic [LW:0]   qm;
	logic [W-1:0]  sat_res;

	assign ma    = a[W-1] ? W'(-a) : W'(a);
	assign mb    = b[W-1] ? W'(-b) : W'(b);
	assign trial = {rem_q, sh_q[LW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_comb begin
		if (op_div_q) begin
			qm = {1'b0, acc_q};
		end else begin
			qm = ({1'b0, acc_q} + RND) >> FRAC_BITS;
		end
		if (neg_q) begin
			sat_res = (qm > LIM) ? ~WMAX : W'(-qm[W-1:0]);
		end else begin
			sat_res = (qm >= LIM) ? WMAX : qm[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ustate_q <= U_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= (ustate_q == U_FIN);
			case (ustate_q)
				U_IDLE: begin
					if (req.start) begin
						ustate_q <= U_RUN;
					end
				end
				U_RUN: begin
					if (cnt_q == CW'(1)) begin
						ustate_q <= U_FIN;
					end
				end
				U_FIN: begin
					ustate_q <= U_IDLE;
				end
				default: ustate_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ustate_q)
			U_IDLE: begin
				if (req.start) begin
					op_div_q <= req.op_div;
					neg_q    <= a[W-1] ^ b[W-1];
					acc_q    <= '0;
					rem_q    <= '0;
					den_q    <= mb;
					mplr_q   <= mb;
					if (req.op_div) begin
						sh_q  <= LW'(ma) << (LW - W);
						cnt_q <= CW'(W + FRAC_BITS);
					end else begin
						sh_q  <= LW'(ma);
						cnt_q <= CW'(W);
					end
				end
			end
			U_RUN: begin
				cnt_q <= cnt_q - CW'(1);
				sh_q  <= sh_q << 1;
				if (op_div_q) begin
					rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
					acc_q <= {acc_q[LW-2:0], fits};
				end else begin
					mplr_q <= mplr_q >> 1;
					if (mplr_q[0]) begin
						acc_q <= acc_q + sh_q;
					end
				end
			end
			U_FIN: begin
				result_q <= sat_res;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/polar_decomposition_iteration_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_decomposition_iteration_3x3_top: Newton polar iteration, 3x3 matrix
// Sequencer, matrix registers and one shared serial multiply/divide unit.
// ----------------------------------------------------------------------------
// The block takes one 3x3 matrix item and repeats Y = (X + inv(X)^T) / 2
// until the largest entry change falls below the tolerance register, the
// iteration limit is hit, or the determinant is zero. All arithmetic runs
// through one bit-serial unit, with operand fetch (S_OPA, S_OPB) before
// and write-back (S_POST) after each operation. One iteration uses 21
// multiplies and 9 divides, plus the determinant check and the end-of-step
// state. The input side is ready only while no matrix is in work; a
// finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module polar_decomposition_iteration_3x3_top #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_r0c0,
	input  logic signed [31:0] in_r0c1,
	input  logic signed [31:0] in_r0c2,
	input  logic signed [31:0] in_r1c0,
	input  logic signed [31:0] in_r1c1,
	input  logic signed [31:0] in_r1c2,
	input  logic signed [31:0] in_r2c0,
	input  logic signed [31:0] in_r2c1,
	input  logic signed [31:0] in_r2c2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_r0c0,
	output logic signed [31:0] out_r0c1,
	output logic signed [31:0] out_r0c2,
	output logic signed [31:0] out_r1c0,
	output logic signed [31:0] out_r1c1,
	output logic signed [31:0] out_r1c2,
	output logic signed [31:0] out_r2c0,
	output logic signed [31:0] out_r2c1,
	output logic signed [31:0] out_r2c2,
	output logic [1:0]         status,
	output logic [7:0]         iterations_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import pdi_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	localparam logic signed [XW-1:0] WMAX_X = XW'({1'b0, {(W - 1){1'b1}}});
	localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
	localparam logic signed [XW-1:0] OMAX_X = XW'({1'b0, {31{1'b1}}});
	localparam logic signed [XW-1:0] OMIN_X = ~OMAX_X;
	localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OPA  = 3'd1;
	localparam logic [2:0] S_OPB  = 3'd2;
	localparam logic [2:0] S_RUN  = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_END  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	// Phases of one iteration.
	localparam logic [1:0] PH_COF1 = 2'd0;
	localparam logic [1:0] PH_COF2 = 2'd1;
	localparam logic [1:0] PH_DET  = 2'd2;
	localparam logic [1:0] PH_DIV  = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  ph_q;
	logic [3:0]  k_q;
	logic [7:0]  steps_q;
	logic        start_q;

	logic [15:0] tol_q;
	logic [7:0]  limit_q;
	logic        fatal_q;

	logic signed [W-1:0] x_q [9];
	logic signed [W-1:0] cof_q [9];
	logic signed [W-1:0] det_q;
	logic signed [W-1:0] tmp_q;
	logic signed [W-1:0] opa_q;
	logic signed [W-1:0] opb_q;
	logic signed [W-1:0] xk_q;
	logic [W:0]          maxd_q;

	logic               out_valid_q;
	logic signed [31:0] out_m_q [9];
	logic [1:0]         status_q;
	logic [1:0]         fin_status_q;
	logic [7:0]         iter_q;

	logic [31:0]         in_m [9];
	logic signed [W-1:0] in_sat [9];
	logic [31:0]         x_out [9];

	arith_req_t          ar_req;
	logic                ar_done;
	logic signed [W-1:0] ar_res;

	cof_idx_t            ci;
	logic [3:0]          ia;
	logic [3:0]          ib;
	logic [3:0]          rd_idx;
	logic signed [W-1:0] rd_x;
	logic signed [W-1:0] rd_c;

	logic [W:0]          sub_s;
	logic [W:0]          add_s;
	logic [W:0]          hsum;
	logic [W:0]          diff;
	logic [W:0]          dmag;
	logic signed [W-1:0] sub_sat;
	logic signed [W-1:0] add_sat;
	logic signed [W-1:0] y_val;

	assign in_m[0] = in_r0c0;
	assign in_m[1] = in_r0c1;
	assign in_m[2] = in_r0c2;
	assign in_m[3] = in_r1c0;
	assign in_m[4] = in_r1c1;
	assign in_m[5] = in_r1c2;
	assign in_m[6] = in_r2c0;
	assign in_m[7] = in_r2c1;
	assign in_m[8] = in_r2c2;

	// Inputs saturate to the word width; results saturate to 32 bits.
	for (genvar g = 0; g < 9; g++) begin : g_conv
		logic signed [XW-1:0] ie;
		logic signed [XW-1:0] xe;
		assign ie = XW'(signed'(in_m[g]));
		assign xe = XW'(x_q[g]);
		assign in_sat[g] = (ie > WMAX_X) ? W'(WMAX_X) : ((ie < WMIN_X) ? W'(WMIN_X) : W'(ie));
		assign x_out[g] = (xe > OMAX_X) ? 32'(OMAX_X) : ((xe < OMIN_X) ? 32'(OMIN_X) : 32'(xe));
	end

	// One read port on the matrix registers; operands are fetched in turn.
	always_comb begin
		ci = cof_idx(k_q);
		case (ph_q)
			PH_COF1: begin
				ia = ci.a1;
				ib = ci.b1;
			end
			PH_COF2: begin
				ia = ci.a2;
				ib = ci.b2;
			end
			default: begin
				ia = k_q;
				ib = k_q;
			end
		endcase
		rd_idx = (state_q == S_OPA) ? ia : ib;
		rd_x   = x_q[rd_idx];
		rd_c   = cof_q[rd_idx];
	end

	// Write-back arithmetic: saturating add and subtract, the floor half sum
	// and the magnitude of the change of one entry.
	always_comb begin
		sub_s = {tmp_q[W-1], tmp_q} - {ar_res[W-1], ar_res};
		add_s = {det_q[W-1], det_q} + {ar_res[W-1], ar_res};
		hsum  = {xk_q[W-1], xk_q} + {ar_res[W-1], ar_res};
		y_val = hsum[W:1];
		diff  = {xk_q[W-1], xk_q} - {y_val[W-1], y_val};
		dmag  = diff[W] ? (W + 1)'(-diff) : diff;
		if (sub_s[W] != sub_s[W-1]) begin
			sub_sat = sub_s[W] ? ~WMAX : WMAX;
		end else begin
			sub_sat = sub_s[W-1:0];
		end
		if (add_s[W] != add_s[W-1]) begin
			add_sat = add_s[W] ? ~WMAX : WMAX;
		end else begin
			add_sat = add_s[W-1:0];
		end
	end

	assign ar_req.start  = start_q;
	assign ar_req.op_div = (ph_q == PH_DIV);

	pdi_arith #(
		.FRAC_BITS (FRAC_BITS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ar_req),
		.a     (opa_q),
		.b     (opb_q),
		.done  (ar_done),
		.result(ar_res)
	);

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= 16'd66;
			limit_q <= 8'd20;
			fatal_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOLERANCE:   tol_q   <= cfg_data;
				CFG_ITER_LIMIT:  limit_q <= cfg_data[7:0];
				CFG_LIMIT_FATAL: fatal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_COF1;
			k_q         <= '0;
			steps_q     <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				x_q[i] <= '0;
			end
		end else begin
			start_q <= (state_q == S_OPB);
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < 9; i++) begin
							x_q[i] <= in_sat[i];
						end
						ph_q    <= PH_COF1;
						k_q     <= '0;
						steps_q <= '0;
						state_q <= S_OPA;
					end
				end
				S_OPA: begin
					opa_q   <= (ph_q == PH_DIV) ? rd_c : rd_x;
					state_q <= S_OPB;
				end
				S_OPB: begin
					if (ph_q == PH_DIV) begin
						opb_q <= det_q;
					end else if (ph_q == PH_DET) begin
						opb_q <= rd_c;
					end else begin
						opb_q <= rd_x;
					end
					xk_q    <= rd_x;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (ar_done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_OPA;
					case (ph_q)
						PH_COF1: begin
							tmp_q <= ar_res;
							ph_q  <= PH_COF2;
						end
						PH_COF2: begin
							cof_q[k_q] <= sub_sat;
							if (k_q == 4'd8) begin
								k_q   <= '0;
								det_q <= '0;
								ph_q  <= PH_DET;
							end else begin
								k_q  <= k_q + 4'd1;
								ph_q <= PH_COF1;
							end
						end
						PH_DET: begin
							det_q <= add_sat;
							if (k_q == 4'd2) begin
								state_q <= S_CHK;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end
						default: begin
							x_q[k_q] <= y_val;
							if (dmag > maxd_q) begin
								maxd_q <= dmag;
							end
							if (k_q == 4'd8) begin
								state_q <= S_END;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end
					endcase
				end
				S_CHK: begin
					if (det_q == '0) begin
						fin_status_q <= ST_SINGULAR;
						state_q      <= S_DONE;
					end else begin
						ph_q    <= PH_DIV;
						k_q     <= '0;
						maxd_q  <= '0;
						state_q <= S_OPA;
					end
				end
				S_END: begin
					steps_q <= steps_q + 8'd1;
					k_q     <= '0;
					ph_q    <= PH_COF1;
					if (maxd_q < (W + 1)'(tol_q)) begin
						fin_status_q <= ST_CONVERGED;
						state_q      <= S_DONE;
					end else if ({1'b0, steps_q} + 9'd1 >= {1'b0, limit_q}) begin
						fin_status_q <= fatal_q ? ST_FATAL : ST_LIMIT;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_OPA;
					end
				end
				S_DONE: begin
					// Hand the item over once the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			for (int i = 0; i < 9; i++) begin
				out_m_q[i] <= x_out[i];
			end
			status_q <= fin_status_q;
			iter_q   <= steps_q;
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign out_r0c0        = out_m_q[0];
	assign out_r0c1        = out_m_q[1];
	assign out_r0c2        = out_m_q[2];
	assign out_r1c0        = out_m_q[3];
	assign out_r1c1        = out_m_q[4];
	assign out_r1c2        = out_m_q[5];
	assign out_r2c0        = out_m_q[6];
	assign out_r2c1        = out_m_q[7];
	assign out_r2c2        = out_m_q[8];
	assign status          = status_q;
	assign iterations_used = iter_q;

	// A converged result always counts the step that converged.
	a_conv_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_CONVERGED) |-> (iterations_used != 8'd0))
		else $error("converged result with zero iterations");

	// An accepted item starts operand fetch in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_OPA))
		else $error("accepted item did not start");

	// The determinant test follows only the last determinant term.
	a_chk_after_det: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (ph_q == PH_DET && k_q == 4'd2))
		else $error("determinant check out of sequence");

	// The unit is started only from operand fetch, and never while busy.
	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == S_RUN && $past(state_q) == S_OPB))
		else $error("arithmetic unit started out of sequence");

endmodule

### tb/polar_decomposition_iteration_3x3_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_decomposition_iteration_3x3_top_tb: self-checking bench for the polar iteration
// Sends 3x3 Q16.16 matrices under several register settings and idle patterns.
// Each returned matrix, status and step count is checked against a predictor
// that runs in the bench.
// ----------------------------------------------------------------------------
module polar_decomposition_iteration_3x3_top_tb;
	import pdi_pkg::*;

	// Index 3 of the register file decodes to nothing; a write there must be ignored.
	localparam logic [1:0] CFG_NONE = 2'd3;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;
	localparam longint CYCLE_LIMIT = 64'd40000000;

	typedef logic signed [31:0] mat_t [9];

	typedef struct {
		mat_t       m;
		logic [1:0] st;
		logic [7:0] steps;
	} polar_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [31:0] in_m [9];
	logic signed [31:0] out_m [9];
	logic [1:0] status, cfg_index;
	logic [7:0] iterations_used;
	logic [15:0] cfg_data;

	// Bench copy of the three registers.
	logic [15:0] tol_reg;
	logic [7:0] limit_reg;
	logic fatal_reg;

	bit no_idle;
	longint cycles;
	int singular_seen, limit_seen, converged_seen;

	polar_decomposition_iteration_3x3_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_r0c0(in_m[0]), .in_r0c1(in_m[1]), .in_r0c2(in_m[2]),
		.in_r1c0(in_m[3]), .in_r1c1(in_m[4]), .in_r1c2(in_m[5]),
		.in_r2c0(in_m[6]), .in_r2c1(in_m[7]), .in_r2c2(in_m[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_r0c0(out_m[0]), .out_r0c1(out_m[1]), .out_r0c2(out_m[2]),
		.out_r1c0(out_m[3]), .out_r1c1(out_m[4]), .out_r1c2(out_m[5]),
		.out_r2c0(out_m[6]), .out_r2c1(out_m[7]), .out_r2c2(out_m[8]),
		.status(status), .iterations_used(iterations_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Saturate a sign and magnitude pair to a 32-bit word.
	function automatic longint sat_word(bit neg, longint unsigned mag);
		if (neg) begin
			if (mag > 64'd2147483648) return WMIN;
			return -longint'(mag);
		end
		if (mag > 64'd2147483647) return WMAX;
		return longint'(mag);
	endfunction

	function automatic longint unsigned mag_of(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	// Rounded Q16.16 product, ties away from zero.
	function automatic longint q_mul(longint a, longint b);
		longint unsigned p;
		p = mag_of(a) * mag_of(b);
		return sat_word((a < 0) != (b < 0), (p + 64'd32768) >> 16);
	endfunction

	// Cofactor over determinant, truncated toward zero.
	function automatic longint q_div(longint c, longint d);
		longint unsigned q;
		q = (mag_of(c) << 16) / mag_of(d);
		return sat_word((c < 0) != (d < 0), q);
	endfunction

	function automatic longint clip(longint v);
		return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
	endfunction

	// Full Newton polar run on one matrix under the given register values.
	function automatic polar_result_t polar_solve(mat_t m, logic [15:0] tol,
		logic [7:0] lim, logic fat);
		polar_result_t r;
		longint x [9], y [9], cof [9];
		longint det, diff;
		longint unsigned maxd;
		int steps, i, j, i1, i2, j1, j2;
		logic [1:0] st;
		steps = 0;
		for (int k = 0; k < 9; k++) x[k] = m[k];
		forever begin
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++) begin
					i1 = (i + 1) % 3; i2 = (i + 2) % 3;
					j1 = (j + 1) % 3; j2 = (j + 2) % 3;
					cof[i*3+j] = clip(q_mul(x[i1*3+j1], x[i2*3+j2])
						- q_mul(x[i1*3+j2], x[i2*3+j1]));
				end
			det = 0;
			for (j = 0; j < 3; j++) det = clip(det + q_mul(x[j], cof[j]));
			if (det == 0) begin
				st = ST_SINGULAR;
				break;
			end
			maxd = 0;
			for (int k = 0; k < 9; k++) begin
				y[k] = (x[k] + q_div(cof[k], det)) >>> 1;
				diff = x[k] - y[k];
				if (mag_of(diff) > maxd) maxd = mag_of(diff);
			end
			for (int k = 0; k < 9; k++) x[k] = y[k];
			steps++;
			if (maxd < tol) begin
				st = ST_CONVERGED;
				break;
			end
			if (steps >= lim) begin
				st = fat ? ST_FATAL : ST_LIMIT;
				break;
			end
		end
		for (int k = 0; k < 9; k++) r.m[k] = x[k][31:0];
		r.st = st;
		r.steps = steps[7:0];
		return r;
	endfunction

	// Holds the results still owed by the block, oldest first.
	class polar_scoreboard;
		polar_result_t owed [$];
		int errors = 0;
		int sent = 0;
		int checked = 0;

		function void note_input(mat_t m, logic [15:0] tol, logic [7:0] lim, logic fat);
			owed.push_back(polar_solve(m, tol, lim, fat));
			sent++;
		endfunction

		function void check_result(mat_t m, logic [1:0] st, logic [7:0] steps);
			polar_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			for (int k = 0; k < 9; k++)
				if (m[k] !== e.m[k]) begin
					$display("%0t: entry %0d expected %0d actual %0d", $time, k, e.m[k], m[k]);
					errors++;
				end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (steps !== e.steps) begin
				$display("%0t: iterations expected %0d actual %0d", $time, e.steps, steps);
				errors++;
			end
		endfunction
	endclass

	polar_scoreboard sb;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none at all in the no-idle phases.
	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Result side: random stalls on out_ready, and the check of every accepted result.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				sb.check_result(out_m, status, iterations_used);
				case (status)
					ST_SINGULAR: singular_seen++;
					ST_CONVERGED: converged_seen++;
					default: limit_seen++;
				endcase
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One register write, held until the block takes it; the bench copy follows.
	// The channel then idles with cfg_valid low before returning, so that writes
	// never touch cfg_valid twice in one time step.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TOLERANCE: tol_reg = val;
			CFG_ITER_LIMIT: limit_reg = val[7:0];
			CFG_LIMIT_FATAL: fatal_reg = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Sends one matrix item. The valid is only lowered when a gap follows, so a
	// back-to-back item never sees two assignments to in_valid in one step.
	task automatic send_matrix(mat_t m);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		for (int k = 0; k < 9; k++) in_m[k] <= m[k];
		do @(posedge clk); while (!in_ready);
		sb.note_input(m, tol_reg, limit_reg, fatal_reg);
	endtask

	// Waits until every expected result has come back, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.owed.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		return $urandom();
	endfunction

	// A signed permutation scaled by a factor, plus small noise: the kind of matrix
	// that converges in a few steps and so exercises the normal path.
	function automatic mat_t near_orthogonal();
		mat_t m;
		int perm [3];
		int t, a;
		longint s, noise;
		perm = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			a = $urandom_range(i);
			t = perm[i]; perm[i] = perm[a]; perm[a] = t;
		end
		s = $urandom_range(ONE / 4, 4 * ONE);
		noise = $urandom_range(0, 3) == 0 ? ONE / 2 : ONE / 16;
		for (int k = 0; k < 9; k++)
			m[k] = longint'($urandom_range(0, 2 * noise)) - noise;
		for (int i = 0; i < 3; i++)
			m[i*3+perm[i]] = $urandom_range(1) ? s + m[i*3+perm[i]] : -s + m[i*3+perm[i]];
		return m;
	endfunction

	function automatic mat_t random_matrix();
		mat_t m;
		int p;
		p = $urandom_range(99);
		if (p < 70) return near_orthogonal();
		for (int k = 0; k < 9; k++) begin
			if (p < 85) m[k] = rand_word();
			else if (p < 92) m[k] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
			else m[k] = $urandom_range(1) ? 32'sd0 : rand_word();
		end
		// Now and then make the first two rows equal so the exact determinant is zero.
		if ($urandom_range(9) == 0)
			for (int j = 0; j < 3; j++) m[3+j] = m[j];
		return m;
	endfunction

	function automatic mat_t diag(longint a, longint b, longint c);
		mat_t m;
		for (int k = 0; k < 9; k++) m[k] = 0;
		m[0] = a; m[4] = b; m[8] = c;
		return m;
	endfunction

	function automatic mat_t fill(longint v);
		mat_t m;
		for (int k = 0; k < 9; k++) m[k] = v;
		return m;
	endfunction

	initial begin
		mat_t m;
		int phase_items;
		sb = new();
		cycles = 0;
		no_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TOLERANCE;
		cfg_data = '0;
		for (int k = 0; k < 9; k++) in_m[k] = '0;
		tol_reg = 16'd66;
		limit_reg = 8'd20;
		fatal_reg = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values: identity, zero, the extreme
		// words, saturating products, a zero row, a determinant that rounds to zero,
		// negated and scaled matrices, and a permutation.
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(fill(0));
		send_matrix(fill(WMAX));
		send_matrix(fill(WMIN));
		send_matrix(diag(WMAX, WMIN, WMAX));
		send_matrix(diag(-ONE, -ONE, -ONE));
		send_matrix(diag(2 * ONE, ONE / 2, 3 * ONE));
		send_matrix(diag(1, 1, 1));
		send_matrix(diag(100 * ONE, 100 * ONE, 100 * ONE));
		m = diag(ONE, ONE, ONE);
		m[3] = 0; m[4] = 0; m[5] = 0;
		send_matrix(m);
		m = fill(0);
		m[1] = ONE; m[5] = -ONE; m[6] = ONE;
		send_matrix(m);
		m = diag(WMIN, WMIN, WMIN);
		m[1] = WMAX; m[3] = WMAX;
		send_matrix(m);
		send_matrix(diag(ONE, ONE, -ONE));
		drain();

		// Register extremes: limit zero acts as one, index three is ignored, and
		// upper data bits beyond each register's width are dropped.
		write_reg(CFG_NONE, 16'hFFFF);
		write_reg(CFG_ITER_LIMIT, 16'hFF00);
		write_reg(CFG_LIMIT_FATAL, 16'hFFFE);
		write_reg(CFG_TOLERANCE, 16'd0);
		send_matrix(diag(2 * ONE, ONE, ONE));
		send_matrix(near_orthogonal());
		drain();
		write_reg(CFG_LIMIT_FATAL, 16'd1);
		write_reg(CFG_TOLERANCE, 16'hFFFF);
		send_matrix(diag(3 * ONE, ONE, ONE));
		send_matrix(fill(WMAX));
		drain();
		write_reg(CFG_TOLERANCE, 16'd66);
		write_reg(CFG_ITER_LIMIT, 16'd255);
		for (int n = 0; n < 6; n++) send_matrix(near_orthogonal());
		drain();

		// Random phases, each under new register values; the sender pauses at every
		// phase boundary until all results are back.
		for (int ph = 0; ph < 10; ph++) begin
			no_idle = (ph % 4 == 3);
			case ($urandom_range(3))
				0: write_reg(CFG_TOLERANCE, 16'($urandom_range(0, 20)));
				1: write_reg(CFG_TOLERANCE, 16'($urandom_range(60, 600)));
				2: write_reg(CFG_TOLERANCE, 16'($urandom_range(1000, 65535)));
				default: write_reg(CFG_TOLERANCE, 16'd66);
			endcase
			write_reg(CFG_ITER_LIMIT, 16'($urandom_range(1, tol_reg < 20 ? 2 : 5)));
			write_reg(CFG_LIMIT_FATAL, 16'($urandom_range(1)));
			phase_items = 73;
			for (int n = 0; n < phase_items; n++) send_matrix(random_matrix());
			drain();
		end

		$display("Sent %0d matrices over 14 register settings; %0d results checked.",
			sb.sent, sb.checked);
		$display("Outcomes: %0d converged, %0d hit the limit, %0d singular.",
			converged_seen, limit_seen, singular_seen);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/pdi_pkg.sv
hdl/pdi_arith.sv
hdl/polar_decomposition_iteration_3x3_top.sv
tb/polar_decomposition_iteration_3x3_top_tb.sv
